FILE: rtl/ifm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Input capture frequency meter package
// Shared widths, reset values, register indexes and types.
// ----------------------------------------------------------------------------
package ifm_pkg;

    localparam int COUNTER_BITS_DEF = 16;
    localparam int WRAP_BITS_DEF    = 8;

    localparam int PERIOD_W  = 24;
    localparam int FREQ_W    = 30;
    localparam int CLOCK_W   = 30;
    localparam int CFG_IDX_W = 1;

    localparam logic [CLOCK_W-1:0]  CLOCK_HZ_RESET = 30'd8000000;
    localparam logic [PERIOD_W-1:0] PERIOD_MAX     = '1;

    localparam logic [CFG_IDX_W-1:0] REG_CLOCK_HZ    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EDGE_RISING = 1'd1;

    typedef enum logic [1:0] {
        PHASE_IDLE    = 2'd0,
        PHASE_ARMED   = 2'd1,
        PHASE_MEASURE = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        DIV_IDLE = 2'd0,
        DIV_RUN  = 2'd1,
        DIV_DONE = 2'd2
    } div_state_t;

    typedef struct packed {
        logic [PERIOD_W-1:0] period;
        logic                too_long;
    } job_t;

endpackage

FILE: rtl/input_capture_frequency_meter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Input capture frequency meter
// Measures the time between two selected edges of a capture pin in timer
// ticks and reports the period and the frequency clock_hz / period.
//
// Channel    Handshake             Payload
// ticks      push / full           pin_level, arm
// results    empty / pop           period_ticks, frequency_hz, too_long
// config     cfg_valid / cfg_ready cfg_index, cfg_data
//
// One tick is taken per clock while push is high and full is low; full
// rises only when two measurements wait behind the divider. A result
// follows the edge that takes its second capture tick, set by the
// one-bit-per-cycle divider (it loads the job from the queue, then forms 30
// quotient bits). A waiting result stalls the divider; ticks keep counting
// until two more measurements queue behind it and full rises. Reset is
// asynchronous; no clearing pass is needed after it.
// ----------------------------------------------------------------------------
module input_capture_frequency_meter #(
    parameter int COUNTER_BITS = ifm_pkg::COUNTER_BITS_DEF,
    parameter int WRAP_BITS    = ifm_pkg::WRAP_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic                          pin_level,
    input  logic                          arm,
    output logic                          empty,
    input  logic                          pop,
    output logic [ifm_pkg::PERIOD_W-1:0]  period_ticks,
    output logic [ifm_pkg::FREQ_W-1:0]    frequency_hz,
    output logic                          too_long,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [ifm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ifm_pkg::CLOCK_W-1:0]   cfg_data
);

    logic [ifm_pkg::CLOCK_W-1:0] clock_hz_reg;
    logic                        edge_rising_reg;

    logic          accept;
    logic          job_valid;
    ifm_pkg::job_t front_job;
    ifm_pkg::job_t queue_job;
    logic          queue_full;
    logic          queue_empty;
    logic          job_take;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clock_hz_reg    <= ifm_pkg::CLOCK_HZ_RESET;
            edge_rising_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                ifm_pkg::REG_CLOCK_HZ:    clock_hz_reg    <= cfg_data;
                ifm_pkg::REG_EDGE_RISING: edge_rising_reg <= cfg_data[0];
                default:                  clock_hz_reg    <= clock_hz_reg;
            endcase
        end
    end

    assign full   = queue_full;
    assign accept = push && !queue_full;

    ifm_front #(
        .COUNTER_BITS (COUNTER_BITS),
        .WRAP_BITS    (WRAP_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .pin_level   (pin_level),
        .arm         (arm),
        .edge_rising (edge_rising_reg),
        .job_valid   (job_valid),
        .job         (front_job)
    );

    ifm_job_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (job_valid),
        .wr_data (front_job),
        .rd_en   (job_take),
        .rd_data (queue_job),
        .full    (queue_full),
        .empty   (queue_empty)
    );

    ifm_divider u_divider (
        .clk          (clk),
        .rst_n        (rst_n),
        .job_ready    (!queue_empty),
        .job          (queue_job),
        .job_take     (job_take),
        .clock_hz     (clock_hz_reg),
        .pop          (pop),
        .empty        (empty),
        .period_ticks (period_ticks),
        .frequency_hz (frequency_hz),
        .too_long     (too_long)
    );

endmodule

FILE: rtl/ifm_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Capture front end
// Free-running tick counter, edge detection, wrap counting and period
// calculation. Emits one measurement request per completed period.
// ----------------------------------------------------------------------------
module ifm_front #(
    parameter int COUNTER_BITS = ifm_pkg::COUNTER_BITS_DEF,
    parameter int WRAP_BITS    = ifm_pkg::WRAP_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          accept,
    input  logic          pin_level,
    input  logic          arm,
    input  logic          edge_rising,
    output logic          job_valid,
    output ifm_pkg::job_t job
);

    localparam int TOT_W  = WRAP_BITS + COUNTER_BITS;
    localparam int DIFF_W = ((TOT_W > ifm_pkg::PERIOD_W) ? TOT_W : ifm_pkg::PERIOD_W) + 1;
    localparam logic [WRAP_BITS-1:0] WRAP_MAX = '1;

    logic [COUNTER_BITS-1:0] tick_reg, tick_next;
    logic [COUNTER_BITS-1:0] first_reg, first_next;
    logic [WRAP_BITS-1:0]    wrap_reg, wrap_next;
    ifm_pkg::phase_t         phase_reg, phase_next;
    logic                    prev_pin_reg, prev_pin_next;
    logic                    sat_reg, sat_next;

    ifm_pkg::phase_t         phase_eff;
    logic [WRAP_BITS-1:0]    wrap_eff;
    logic                    sat_eff;
    logic                    edge_hit;
    logic [COUNTER_BITS-1:0] tick_inc;
    logic [DIFF_W-1:0]       diff;
    logic [DIFF_W-2:0]       diff_mag;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg     <= '0;
            first_reg    <= '0;
            wrap_reg     <= '0;
            phase_reg    <= ifm_pkg::PHASE_IDLE;
            prev_pin_reg <= 1'b1;
            sat_reg      <= 1'b0;
        end
        else
        begin
            tick_reg     <= tick_next;
            first_reg    <= first_next;
            wrap_reg     <= wrap_next;
            phase_reg    <= phase_next;
            prev_pin_reg <= prev_pin_next;
            sat_reg      <= sat_next;
        end
    end

    // The span is formed from the wrap count and counter as one wide value.
    assign diff     = DIFF_W'({wrap_eff, tick_reg}) - DIFF_W'(first_reg);
    assign diff_mag = diff[DIFF_W-2:0];
    assign tick_inc = tick_reg + 1'b1;

    always_comb
    begin
        tick_next     = tick_reg;
        first_next    = first_reg;
        wrap_next     = wrap_reg;
        phase_next    = phase_reg;
        prev_pin_next = prev_pin_reg;
        sat_next      = sat_reg;
        job_valid     = 1'b0;
        job.period    = ifm_pkg::PERIOD_MAX;
        job.too_long  = 1'b1;

        // An arm request restarts the measurement before edge handling.
        if (arm)
        begin
            phase_eff = ifm_pkg::PHASE_ARMED;
            wrap_eff  = '0;
            sat_eff   = 1'b0;
        end
        else
        begin
            phase_eff = phase_reg;
            wrap_eff  = wrap_reg;
            sat_eff   = sat_reg;
        end

        if (edge_rising)
            edge_hit = !prev_pin_reg && pin_level;
        else
            edge_hit = prev_pin_reg && !pin_level;

        if (!sat_eff && !diff[DIFF_W-1] && (diff_mag <= (DIFF_W-1)'(ifm_pkg::PERIOD_MAX)))
        begin
            job.period   = diff_mag[ifm_pkg::PERIOD_W-1:0];
            job.too_long = 1'b0;
        end
        else if (!sat_eff && diff[DIFF_W-1])
        begin
            job.period   = '0;
            job.too_long = 1'b0;
        end

        if (accept)
        begin
            prev_pin_next = pin_level;
            wrap_next     = wrap_eff;
            sat_next      = sat_eff;
            tick_next     = tick_inc;
            unique case (phase_eff)
                ifm_pkg::PHASE_ARMED:
                begin
                    phase_next = ifm_pkg::PHASE_ARMED;
                    if (edge_hit)
                    begin
                        first_next = tick_reg;
                        phase_next = ifm_pkg::PHASE_MEASURE;
                    end
                end
                ifm_pkg::PHASE_MEASURE:
                begin
                    phase_next = ifm_pkg::PHASE_MEASURE;
                    if (edge_hit)
                    begin
                        job_valid  = 1'b1;
                        phase_next = ifm_pkg::PHASE_IDLE;
                    end
                end
                default:
                begin
                    phase_next = ifm_pkg::PHASE_IDLE;
                end
            endcase

            // Wraps are counted only while waiting for the edge that ends the period.
            if (tick_inc == '0 && phase_next == ifm_pkg::PHASE_MEASURE)
            begin
                if (wrap_eff == WRAP_MAX)
                    sat_next = 1'b1;
                else
                    wrap_next = wrap_eff + 1'b1;
            end
        end
    end

endmodule

FILE: rtl/ifm_job_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Measurement request queue
// Two-entry queue that decouples the capture front end from the divider.
// ----------------------------------------------------------------------------
module ifm_job_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  ifm_pkg::job_t wr_data,
    input  logic          rd_en,
    output ifm_pkg::job_t rd_data,
    output logic          full,
    output logic          empty
);

    ifm_pkg::job_t slot_reg [2];
    logic          wr_ptr_reg, wr_ptr_next;
    logic          rd_ptr_reg, rd_ptr_next;
    logic [1:0]    count_reg, count_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            slot_reg[wr_ptr_reg] <= wr_data;
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
            wr_ptr_next = !wr_ptr_reg;
        if (rd_en)
            rd_ptr_next = !rd_ptr_reg;
        if (wr_en && !rd_en)
            count_next = count_reg + 2'd1;
        else if (!wr_en && rd_en)
            count_next = count_reg - 2'd1;
    end

    assign rd_data = slot_reg[rd_ptr_reg];
    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);

endmodule

FILE: rtl/ifm_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frequency divider back end
// Restoring shift-subtract division of clock_hz by the period, one quotient
// bit per cycle, with a result register that holds until popped.
// ----------------------------------------------------------------------------
module ifm_divider (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         job_ready,
    input  ifm_pkg::job_t                job,
    output logic                         job_take,
    input  logic [ifm_pkg::CLOCK_W-1:0]  clock_hz,
    input  logic                         pop,
    output logic                         empty,
    output logic [ifm_pkg::PERIOD_W-1:0] period_ticks,
    output logic [ifm_pkg::FREQ_W-1:0]   frequency_hz,
    output logic                         too_long
);

    localparam int CNT_W = $clog2(ifm_pkg::FREQ_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(ifm_pkg::FREQ_W - 1);

    ifm_pkg::div_state_t          state_reg, state_next;
    logic [CNT_W-1:0]             cnt_reg, cnt_next;
    logic [ifm_pkg::PERIOD_W-1:0] rem_reg, rem_next;
    logic [ifm_pkg::FREQ_W-1:0]   quo_reg, quo_next;
    logic [ifm_pkg::PERIOD_W-1:0] div_reg, div_next;
    logic                         flag_reg, flag_next;

    logic [ifm_pkg::PERIOD_W:0]   shifted;
    logic [ifm_pkg::PERIOD_W:0]   trial;
    logic                         fits;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ifm_pkg::DIV_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        div_reg  <= div_next;
        flag_reg <= flag_next;
    end

    // The quotient register starts as the dividend and shifts quotient bits in.
    assign shifted = {rem_reg, quo_reg[ifm_pkg::FREQ_W-1]};
    assign trial   = shifted - {1'b0, div_reg};
    assign fits    = (shifted >= {1'b0, div_reg});

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        div_next   = div_reg;
        flag_next  = flag_reg;
        job_take   = 1'b0;
        unique case (state_reg)
            ifm_pkg::DIV_IDLE:
            begin
                if (job_ready)
                begin
                    job_take   = 1'b1;
                    rem_next   = '0;
                    quo_next   = ifm_pkg::FREQ_W'(clock_hz);
                    div_next   = job.period;
                    flag_next  = job.too_long;
                    cnt_next   = LAST_STEP;
                    state_next = ifm_pkg::DIV_RUN;
                end
            end
            ifm_pkg::DIV_RUN:
            begin
                rem_next = fits ? trial[ifm_pkg::PERIOD_W-1:0] : shifted[ifm_pkg::PERIOD_W-1:0];
                quo_next = {quo_reg[ifm_pkg::FREQ_W-2:0], fits};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                    state_next = ifm_pkg::DIV_DONE;
            end
            ifm_pkg::DIV_DONE:
            begin
                if (pop)
                    state_next = ifm_pkg::DIV_IDLE;
            end
            default:
            begin
                state_next = ifm_pkg::DIV_IDLE;
            end
        endcase
    end

    assign empty        = (state_reg != ifm_pkg::DIV_DONE);
    assign period_ticks = div_reg;
    // A zero period reports a zero frequency.
    assign frequency_hz = (div_reg == '0) ? '0 : quo_reg;
    assign too_long     = flag_reg;

endmodule
